/* design/assert_macros.svh */
// Shared assertion helpers, clocked on clk_i and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hbf assertion failed");

`define HBF_ASSERT_NEVER(lbl, cond) `HBF_ASSERT(lbl, !(cond))

`endif

/* design/hbf_pkg.sv */
`default_nettype none
package hbf_pkg;

  localparam int CW = 32;
  localparam int WF = 16;
  localparam int WW = WF + 1;

  localparam logic [WW-1:0] W_ONE     = WW'(1 << WF);
  localparam logic [18:0]   THREE_ONE = 19'(3 * (1 << WF));
  localparam logic [14:0]   FLAT_FULL = 15'd25600;
  // floor(y / 25) = (y * RCP) >> 26 for y below 2^21
  localparam logic [21:0]   RCP       = 22'd2684355;

  localparam logic [2:0] CFG_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_RADIUS     = 3'd2;
  localparam logic [2:0] CFG_STRENGTH   = 3'd3;
  localparam logic [2:0] CFG_FALLOFF    = 3'd4;
  localparam logic [2:0] CFG_SHAPE      = 3'd5;
  localparam logic [2:0] CFG_MODE       = 3'd6;
  localparam logic [2:0] CFG_TARGET     = 3'd7;

  localparam logic [1:0] SHAPE_LINEAR = 2'd0;
  localparam logic [1:0] SHAPE_SMOOTH = 2'd1;
  localparam logic [1:0] SHAPE_SPHERE = 2'd2;
  localparam logic [1:0] SHAPE_TIP    = 2'd3;

  localparam logic [1:0] MODE_RAISE   = 2'd0;
  localparam logic [1:0] MODE_LOWER   = 2'd1;
  localparam logic [1:0] MODE_FLATTEN = 2'd2;

  typedef enum logic [1:0] {WK_ZERO, WK_FULL, WK_BAND} wkind_e;

  typedef struct packed {
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic signed [CW-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] new_height;
    logic [WW-1:0]        brush_weight;
    logic                 changed;
  } result_t;

  typedef struct packed {
    logic          inr;
    logic [23:0]   ax;
    logic [23:0]   ay;
    logic [CW-1:0] vz;
  } mid_item_t;

  typedef struct packed {
    logic [CW-1:0] center_x;
    logic [CW-1:0] center_y;
    logic [23:0]   radius;
    logic [23:0]   strength;
    logic [WW-1:0] falloff;
    logic [1:0]    shape;
    logic [1:0]    mode;
    logic [CW-1:0] target;
  } cfg_t;

endpackage
`default_nettype wire

/* design/hbf_front.sv */
`default_nettype none
module hbf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbf_pkg::cfg_t    cfg_i,
  input  logic             push_i,
  input  hbf_pkg::vertex_t vtx_i,
  output logic             full_o,
  input  logic             q_full_i,
  output logic             q_wr_o,
  output hbf_pkg::mid_item_t q_item_o
);
  import hbf_pkg::*;

  logic      fv_q, fv_d;
  mid_item_t item_q, item_d;
  logic      adv;
  logic signed [CW:0] dx, dy;
  logic [CW:0] ax, ay;

  always_comb begin
    dx = {vtx_i.vertex_x[CW-1], vtx_i.vertex_x} - {cfg_i.center_x[CW-1], cfg_i.center_x};
    dy = {vtx_i.vertex_y[CW-1], vtx_i.vertex_y} - {cfg_i.center_y[CW-1], cfg_i.center_y};
    ax = dx[CW] ? (~dx + 1'b1) : dx;
    ay = dy[CW] ? (~dy + 1'b1) : dy;
    // bounding box test keeps the squares inside 48 bits
    item_d.inr = (cfg_i.radius != '0) && (ax <= (CW+1)'(cfg_i.radius))
                 && (ay <= (CW+1)'(cfg_i.radius));
    item_d.ax  = ax[23:0];
    item_d.ay  = ay[23:0];
    item_d.vz  = vtx_i.vertex_z;
  end

  assign adv    = !fv_q || !q_full_i;
  assign full_o = !adv;
  assign q_wr_o = fv_q && !q_full_i;
  assign q_item_o = item_q;
  assign fv_d   = adv ? push_i : fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push_i) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

/* design/hbf_queue.sv */
`default_nettype none
module hbf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  hbf_pkg::mid_item_t wr_item_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output hbf_pkg::mid_item_t rd_item_o,
  output logic               nonempty_o
);
  import hbf_pkg::*;

  mid_item_t   mem_q [4];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;

  assign full_o     = cnt_q == 3'd4;
  assign nonempty_o = cnt_q != 3'd0;
  assign rd_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en_i) wp_q <= wp_q + 2'd1;
      if (rd_en_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr_en_i) - 3'(rd_en_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

/* design/hbf_back.sv */
`default_nettype none
module hbf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbf_pkg::cfg_t      cfg_i,
  input  logic               head_v_i,
  input  hbf_pkg::mid_item_t head_i,
  output logic               head_pop_o,
  input  logic               ofull_i,
  output logic               tail_v_o,
  output hbf_pkg::result_t   tail_o
);
  import hbf_pkg::*;

  localparam int S_SUM  = 1;
  localparam int S_DIV  = 2;
  localparam int S_SQ1  = S_DIV + 33;
  localparam int S_CLS  = S_SQ1 + 17;
  localparam int S_DIV2 = S_CLS + 1;
  localparam int S_SQR  = S_DIV2 + 16;
  localparam int S_ARG  = S_SQR + 1;
  localparam int S_SQ2  = S_ARG + 1;
  localparam int S_WSEL = S_SQ2 + 17;
  localparam int S_MUL  = S_WSEL + 1;
  localparam int S_RCP  = S_MUL + 1;
  localparam int S_MAG  = S_RCP + 1;
  localparam int S_OUT  = S_MAG + 1;
  localparam int NSTG   = S_OUT + 1;

  typedef struct packed {
    logic          inr;
    wkind_e        kind;
    logic [CW-1:0] vz;
    logic [23:0]   ax;
    logic [23:0]   ay;
    logic [47:0]   pa;
    logic [47:0]   pb;
    logic [47:0]   rsq;
    logic [49:0]   rem;
    logic [32:0]   q;
    logic [34:0]   sn;
    logic [34:0]   sres;
    logic [17:0]   rem2;
    logic [16:0]   fs;
    logic [15:0]   t;
    logic [33:0]   sq;
    logic [20:0]   sm;
    logic [16:0]   w;
    logic [40:0]   pr;
    logic [31:0]   pf;
    logic [43:0]   ym;
    logic [CW-1:0] nzrl;
    logic          dneg;
    logic [32:0]   absd;
    logic [49:0]   mp;
    result_t       res;
  } pipe_t;

  function automatic pipe_t stage_fn(input int s, input pipe_t p, input cfg_t c);
    pipe_t       o;
    logic [49:0] rs, dsq;
    logic [34:0] n, rb, bitv;
    int          j;
    logic [17:0] r2;
    logic [16:0] f, beg, d, u, wc, blend;
    logic [18:0] fac;
    logic [36:0] prod;
    logic [14:0] bb;
    logic [33:0] sum, nzf;
    logic [32:0] diff;
    o = p;
    if (s == S_SUM) begin
      dsq   = {2'b0, p.pa} + {2'b0, p.pb};
      o.rem = dsq;
      o.inr = p.inr && (dsq <= {2'b0, p.rsq});
      o.q   = '0;
    end else if (s >= S_DIV && s < S_SQ1) begin
      // restoring division, one quotient bit per stage
      rs  = (s == S_DIV) ? p.rem : {p.rem[48:0], 1'b0};
      o.q = (s == S_DIV) ? 33'd0 : {p.q[31:0], 1'b0};
      if (rs >= {2'b0, p.rsq}) begin
        o.rem  = rs - {2'b0, p.rsq};
        o.q[0] = 1'b1;
      end else begin
        o.rem = rs;
      end
    end else if ((s >= S_SQ1 && s < S_CLS) || (s >= S_SQ2 && s < S_WSEL)) begin
      j    = (s >= S_SQ2) ? (s - S_SQ2) : (s - S_SQ1);
      n    = (s == S_SQ1) ? {2'b0, p.q} : p.sn;
      rb   = (s == S_SQ1 || s == S_SQ2) ? 35'd0 : p.sres;
      bitv = 35'd1 << (32 - 2 * j);
      if (n >= rb + bitv) begin
        o.sn   = n - (rb + bitv);
        o.sres = (rb >> 1) + bitv;
      end else begin
        o.sn   = n;
        o.sres = rb >> 1;
      end
    end else if (s == S_CLS) begin
      f   = (c.falloff > W_ONE) ? W_ONE : c.falloff;
      beg = W_ONE - f;
      d   = p.sres[16:0];
      priority if (d >= W_ONE) o.kind = WK_ZERO;
      else if (f == '0)        o.kind = WK_FULL;
      else if (d <= beg)       o.kind = WK_FULL;
      else                     o.kind = WK_BAND;
      o.rem2 = {1'b0, d - beg};
      o.fs   = f;
      o.t    = '0;
    end else if (s >= S_DIV2 && s < S_SQR) begin
      r2  = {p.rem2[16:0], 1'b0};
      o.t = {p.t[14:0], 1'b0};
      if (r2 >= {1'b0, p.fs}) begin
        o.rem2 = r2 - {1'b0, p.fs};
        o.t[0] = 1'b1;
      end else begin
        o.rem2 = r2;
      end
    end else if (s == S_SQR) begin
      u    = (c.shape == SHAPE_TIP) ? (W_ONE - {1'b0, p.t}) : {1'b0, p.t};
      o.sq = 34'(u) * 34'(u);
    end else if (s == S_ARG) begin
      fac  = THREE_ONE - {2'b0, p.t, 1'b0};
      prod = 37'(p.sq[33:16]) * 37'(fac);
      o.sm = prod[36:16];
      o.sn = (35'd1 << 32) - {1'b0, p.sq};
    end else if (s == S_WSEL) begin
      unique case (c.shape)
        SHAPE_LINEAR: wc = W_ONE - {1'b0, p.t};
        SHAPE_SMOOTH: wc = (p.sm > 21'(W_ONE)) ? 17'd0 : W_ONE - p.sm[16:0];
        SHAPE_SPHERE: wc = p.sres[16:0];
        SHAPE_TIP:    wc = (p.sres > 35'(W_ONE)) ? 17'd0 : W_ONE - p.sres[16:0];
        default:      wc = '0;
      endcase
      if (!p.inr) begin
        o.w = '0;
      end else begin
        unique case (p.kind)
          WK_FULL: o.w = W_ONE;
          WK_BAND: o.w = wc;
          default: o.w = '0;
        endcase
      end
    end else if (s == S_MUL) begin
      bb   = (c.strength > 24'(FLAT_FULL)) ? FLAT_FULL : c.strength[14:0];
      o.pr = 41'(c.strength) * 41'(p.w);
      o.pf = 32'(bb) * 32'(p.w);
    end else if (s == S_RCP) begin
      o.ym = 44'(p.pf[31:10]) * 44'(RCP);
      if (c.mode == MODE_LOWER) begin
        sum = {{2{p.vz[CW-1]}}, p.vz} - {9'b0, p.pr[40:16]};
      end else begin
        sum = {{2{p.vz[CW-1]}}, p.vz} + {9'b0, p.pr[40:16]};
      end
      priority if (!sum[33] && sum[32:31] != 2'b00) o.nzrl = {1'b0, {(CW-1){1'b1}}};
      else if (sum[33] && sum[32:31] != 2'b11)      o.nzrl = {1'b1, {(CW-1){1'b0}}};
      else                                          o.nzrl = sum[31:0];
      diff   = {c.target[CW-1], c.target} - {p.vz[CW-1], p.vz};
      o.dneg = diff[32];
      o.absd = diff[32] ? (~diff + 1'b1) : diff;
    end else if (s == S_MAG) begin
      blend = p.ym[42:26];
      o.mp  = 50'(p.absd) * 50'(blend);
    end else if (s == S_OUT) begin
      nzf = p.dneg ? ({{2{p.vz[CW-1]}}, p.vz} - {1'b0, p.mp[48:16]})
                   : ({{2{p.vz[CW-1]}}, p.vz} + {1'b0, p.mp[48:16]});
      o.res.brush_weight = p.w;
      priority if (p.w == '0) begin
        o.res.new_height = p.vz;
        o.res.changed    = 1'b0;
      end else if (c.mode == MODE_RAISE || c.mode == MODE_LOWER) begin
        o.res.new_height = p.nzrl;
        o.res.changed    = 1'b1;
      end else if (c.mode == MODE_FLATTEN) begin
        o.res.new_height = nzf[31:0];
        o.res.changed    = 1'b1;
      end else begin
        o.res.new_height = p.vz;
        o.res.changed    = 1'b0;
      end
    end
    return o;
  endfunction

  pipe_t            stg_q [NSTG];
  pipe_t            nxt   [NSTG];
  logic [NSTG-1:0]  v_q;
  logic             en;

  assign en         = !(v_q[NSTG-1] && ofull_i);
  assign head_pop_o = en && head_v_i;
  assign tail_v_o   = v_q[NSTG-1];
  assign tail_o     = stg_q[NSTG-1].res;

  always_comb begin
    nxt[0]     = '0;
    nxt[0].inr = head_i.inr;
    nxt[0].vz  = head_i.vz;
    nxt[0].ax  = head_i.ax;
    nxt[0].ay  = head_i.ay;
    nxt[0].pa  = 48'(head_i.ax) * 48'(head_i.ax);
    nxt[0].pb  = 48'(head_i.ay) * 48'(head_i.ay);
    nxt[0].rsq = 48'(cfg_i.radius) * 48'(cfg_i.radius);
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stg
    always_comb nxt[k] = stage_fn(k, stg_q[k-1], cfg_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], head_v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q <= nxt;
    end
  end

endmodule
`default_nettype wire

/* design/height_brush_falloff_apply.sv */
`default_nettype none
// Heightfield brush: one vertex word in, one result word out, in order. A new
// vertex is taken every cycle while neither side stalls. A vertex is held in
// the front stage, then written into the queue. The back pipeline is 93
// stages: a 33-step distance-over-radius divider, two 17-step square roots,
// a 16-step falloff-band divider and the blend multipliers, one step per stage.
// Each result is then written into the output buffer.
// A front stage and a 4-word queue decouple input from the back pipeline; a
// 2-word output buffer holds results while pop is low. Write configuration
// only while no vertex is in flight. No post-reset init sequence is needed.
`include "assert_macros.svh"
module height_brush_falloff_apply (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  hbf_pkg::vertex_t vtx_i,
  output logic             empty,
  input  logic             pop,
  output hbf_pkg::result_t res_o
);
  import hbf_pkg::*;

  cfg_t      cfg_q;
  logic      q_full, q_wr, q_rd, q_nonempty;
  mid_item_t q_wr_item, q_rd_item;
  logic      tail_v, ofull, owrite;
  result_t   tail;

  result_t   obuf_q [2];
  logic      owp_q, orp_q;
  logic [1:0] ocnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.radius   <= 24'd256;
      cfg_q.strength <= '0;
      cfg_q.falloff  <= '0;
      cfg_q.shape    <= SHAPE_LINEAR;
      cfg_q.mode     <= MODE_RAISE;
      cfg_q.target   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: cfg_q.center_x <= cfg_wdata_i;
        CFG_CENTER_Y: cfg_q.center_y <= cfg_wdata_i;
        CFG_RADIUS:   cfg_q.radius   <= cfg_wdata_i[23:0];
        CFG_STRENGTH: cfg_q.strength <= cfg_wdata_i[23:0];
        CFG_FALLOFF:  cfg_q.falloff  <= cfg_wdata_i[WW-1:0];
        CFG_SHAPE:    cfg_q.shape    <= cfg_wdata_i[1:0];
        CFG_MODE:     cfg_q.mode     <= cfg_wdata_i[1:0];
        CFG_TARGET:   cfg_q.target   <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  hbf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .vtx_i    (vtx_i),
    .full_o   (full),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_item_o (q_wr_item)
  );

  hbf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (q_wr),
    .wr_item_i  (q_wr_item),
    .full_o     (q_full),
    .rd_en_i    (q_rd),
    .rd_item_o  (q_rd_item),
    .nonempty_o (q_nonempty)
  );

  hbf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_v_i   (q_nonempty),
    .head_i     (q_rd_item),
    .head_pop_o (q_rd),
    .ofull_i    (ofull),
    .tail_v_o   (tail_v),
    .tail_o     (tail)
  );

  // output buffer: results wait here while pop is low
  assign ofull  = ocnt_q == 2'd2;
  assign owrite = tail_v && !ofull;
  assign empty  = ocnt_q == 2'd0;
  assign res_o  = obuf_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (owrite) owp_q <= ~owp_q;
      if (pop && !empty) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(owrite) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (owrite) begin
      obuf_q[owp_q] <= tail;
    end
  end

  `HBF_ASSERT(a_obuf_count, ocnt_q <= 2'd2)
  `HBF_ASSERT(a_weight_max, !empty |-> res_o.brush_weight <= W_ONE)
  `HBF_ASSERT(a_zero_weight_kept, (!empty && res_o.brush_weight == '0) |-> !res_o.changed)
  `HBF_ASSERT(a_tail_hold, (tail_v && ofull) |=> (tail_v && $stable(tail)))

endmodule
`default_nettype wire

/* bench/hbf_checker.sv */
module hbf_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             push,
  input  logic             full,
  input  hbf_pkg::vertex_t vtx_i,
  input  logic             empty,
  input  logic             pop,
  input  hbf_pkg::result_t res_o,
  output int               errors_o,
  output int               pending_o,
  output int               seen_o
);
  import hbf_pkg::*;

  cfg_t      brush;
  result_t   heights_due[$];
  longint    n_changed, n_full, n_band;

  assign pending_o = heights_due.size();

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned band_weight(longint unsigned d);
    longint unsigned one, f, start, t, t2, s, tp;
    one = 64'd1 << WF;
    f = brush.falloff;
    if (d >= one) return 0;
    if (f == 0) return one;
    if (f > one) f = one;
    start = one - f;
    if (d <= start) return one;
    t = ((d - start) << WF) / f;
    if (t > one) t = one;
    case (brush.shape)
      SHAPE_LINEAR: return one - t;
      SHAPE_SMOOTH: begin
        t2 = (t * t) >> WF;
        s = (t2 * (3 * one - 2 * t)) >> WF;
        if (s > one) s = one;
        return one - s;
      end
      SHAPE_SPHERE: return root64(one * one - t * t);
      default: begin
        tp = one - t;
        s = root64(one * one - tp * tp);
        if (s > one) s = one;
        return one - s;
      end
    endcase
  endfunction

  function automatic result_t sculpt(vertex_t v);
    result_t o;
    longint vz, nz, diff, cx, cy;
    longint unsigned r, ax, ay, dsq, rsq, w, st, b, blend, mag, delta;
    longint unsigned one;
    one = 64'd1 << WF;
    vz = longint'(v.vertex_z);
    nz = vz;
    cx = longint'($signed(brush.center_x));
    cy = longint'($signed(brush.center_y));
    r = brush.radius;
    w = 0;
    diff = longint'(v.vertex_x) - cx;
    ax = diff < 0 ? -diff : diff;
    diff = longint'(v.vertex_y) - cy;
    ay = diff < 0 ? -diff : diff;
    if (r != 0 && ax <= r && ay <= r) begin
      dsq = ax * ax + ay * ay;
      rsq = r * r;
      if (dsq <= rsq) begin
        // exact floor(dsq * 2^32 / rsq) without overflow
        w = band_weight(root64(
          64'((128'(dsq) << (2 * WF)) / 128'(rsq))));
      end
    end
    o.changed = 1'b0;
    if (w > 0) begin
      st = brush.strength;
      if (brush.mode == MODE_RAISE || brush.mode == MODE_LOWER) begin
        delta = (st * w) >> WF;
        nz = brush.mode == MODE_RAISE ? vz + longint'(delta) : vz - longint'(delta);
        if (nz > 64'sd2147483647) nz = 64'sd2147483647;
        if (nz < -64'sd2147483648) nz = -64'sd2147483648;
        o.changed = 1'b1;
      end else if (brush.mode == MODE_FLATTEN) begin
        b = st > 25600 ? 25600 : st;
        blend = (b * w) / 25600;
        diff = longint'($signed(brush.target)) - vz;
        mag = ((diff < 0 ? -diff : diff) * blend) >> WF;
        nz = diff < 0 ? vz - longint'(mag) : vz + longint'(mag);
        o.changed = 1'b1;
      end
    end
    if (w == one) n_full++;
    else if (w != 0) n_band++;
    if (o.changed) n_changed++;
    o.new_height = nz[31:0];
    o.brush_weight = w[WW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      brush.center_x <= '0;
      brush.center_y <= '0;
      brush.radius <= 24'd256;
      brush.strength <= '0;
      brush.falloff <= '0;
      brush.shape <= SHAPE_LINEAR;
      brush.mode <= MODE_RAISE;
      brush.target <= '0;
      errors_o = 0;
      seen_o <= 0;
      n_changed = 0;
      n_full = 0;
      n_band = 0;
      heights_due.delete();
    end else begin
      if (push && !full) heights_due.push_back(sculpt(vtx_i));
      if (pop && !empty) begin
        seen_o <= seen_o + 1;
        if (heights_due.size() == 0) begin
          report_mismatch("unexpected word, new_height", res_o.new_height, 0);
        end else begin
          want = heights_due.pop_front();
          if (res_o.new_height !== want.new_height)
            report_mismatch("new_height", res_o.new_height, want.new_height);
          if (res_o.brush_weight !== want.brush_weight)
            report_mismatch("brush_weight", res_o.brush_weight, want.brush_weight);
          if (res_o.changed !== want.changed)
            report_mismatch("changed", res_o.changed, want.changed);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X: brush.center_x <= cfg_wdata_i;
          CFG_CENTER_Y: brush.center_y <= cfg_wdata_i;
          CFG_RADIUS:   brush.radius <= cfg_wdata_i[23:0];
          CFG_STRENGTH: brush.strength <= cfg_wdata_i[23:0];
          CFG_FALLOFF:  brush.falloff <= cfg_wdata_i[WW-1:0];
          CFG_SHAPE:    brush.shape <= cfg_wdata_i[1:0];
          CFG_MODE:     brush.mode <= cfg_wdata_i[1:0];
          CFG_TARGET:   brush.target <= cfg_wdata_i;
          default:      ;
        endcase
      end
    end
  end

  function automatic void summarize();
    $display("covered: %0d words checked, %0d changed, %0d full weight, %0d in band",
             seen_o, n_changed, n_full, n_band);
  endfunction
endmodule

/* bench/tb_height_brush_falloff_apply.sv */
module tb_height_brush_falloff_apply;
  import hbf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  vertex_t     vtx_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     res_o;
  int          errors, pending, seen;
  bit          quiet_tail = 1'b0;
  bit          hold_off = 1'b0;
  logic signed [31:0] cx = 0, cy = 0;
  int unsigned rad = 256;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  height_brush_falloff_apply DUT (.*);

  hbf_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push, .full, .vtx_i,
    .empty, .pop, .res_o, .errors_o(errors), .pending_o(pending), .seen_o(seen)
  );

  initial begin
    #20_000_000;
    $display("height_brush_falloff_apply: mismatch");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 7);
        pop <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // caller is at a falling edge; push drops before the next rising edge
  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  // push one vertex; caller is at a falling edge
  task automatic send_vertex(logic signed [31:0] x, y, z);
    int n;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    push <= 1'b1;
    vtx_i <= '{x, y, z};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_brush(logic [31:0] x, y, logic [23:0] r, logic [23:0] s,
                           logic [16:0] f, logic [1:0] sh, logic [1:0] md,
                           logic [31:0] tg);
    write_reg(CFG_CENTER_X, x);
    write_reg(CFG_CENTER_Y, y);
    write_reg(CFG_RADIUS, 32'(r));
    write_reg(CFG_STRENGTH, 32'(s));
    write_reg(CFG_FALLOFF, 32'(f));
    write_reg(CFG_SHAPE, 32'(sh));
    write_reg(CFG_MODE, 32'(md));
    write_reg(CFG_TARGET, tg);
    cx = x;
    cy = y;
    rad = 32'(r);
    @(negedge clk_i);
  endtask

  // vertex near the brush most of the time, any value otherwise
  task automatic random_vertex();
    logic signed [31:0] x, y, z;
    int span;
    span = rad + rad / 4 + 1;
    z = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = cx + $signed($urandom_range(0, 2 * span)) - span;
      y = cy + $signed($urandom_range(0, 2 * span)) - span;
    end
    case ($urandom_range(0, 5))
      0: z = 32'h7fff_ff00 + $urandom_range(0, 255);
      1: z = 32'h8000_0000 + $urandom_range(0, 255);
      default: ;
    endcase
    send_vertex(x, y, z);
  endtask

  initial begin
    logic [1:0] md, sh;
    logic [23:0] r, s;
    logic [16:0] f;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset brush, then edges and special cases
    send_vertex(0, 0, 100);
    send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    drain();
    set_brush(32'h100, 32'hffff_ff00, 24'd1000, 24'hff_ffff, 17'd65536, SHAPE_LINEAR,
              MODE_RAISE, 32'h0);
    send_vertex(32'h100, 32'hffff_ff00, 32'sh7fff_fff0);
    send_vertex(32'h100 + 500, 32'hffff_ff00, 0);
    send_vertex(32'h100 + 1000, 32'hffff_ff00, 0);
    send_vertex(32'h100 + 1001, 32'hffff_ff00, 0);
    send_vertex(32'h100 + 707, 32'hffff_ff00 + 707, 0);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_brush(0, 0, 24'hff_ffff, 24'd0, k == 0 ? 17'd70000 : 17'd30000, k[1:0],
                k[1:0], 32'h8000_0000);
      send_vertex(0, 0, 32'sh8000_0000);
      send_vertex(32'sh00ee_0000, 0, 5);
      send_vertex(32'sh00ff_fffe, 0, -5);
      send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, -1);
      drain();
    end
    set_brush(0, 0, 24'd1, 24'd25601, 17'd1, SHAPE_SMOOTH, MODE_FLATTEN, 32'h7fff_ffff);
    send_vertex(0, 0, 32'sh8000_0000);
    send_vertex(1, 1, 0);
    drain();
    set_brush(0, 0, 24'd4000, 24'd100, 17'd0, SHAPE_TIP, MODE_LOWER, 0);
    send_vertex(0, 0, 32'sh8000_0000);
    drain();

    // long receiver hold-off so the block fills and pushes back
    hold_off = 1'b1;
    for (int k = 0; k < 150; k++) random_vertex();
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 10) quiet_tail = 1'b1;
      md = 2'($urandom_range(0, 3));
      sh = 2'($urandom_range(0, 3));
      r = ph % 3 == 0 ? 24'hff_ffff
                      : 24'($urandom_range(0, 1) ? $urandom_range(1, 5000) : $urandom);
      if (r == 0) r = 24'd1;
      s = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(0, 30000));
      f = $urandom_range(0, 3) == 0 ? 17'($urandom_range(0, 131071))
                                    : 17'($urandom_range(0, 65536));
      set_brush($urandom, $urandom, r, s, f, sh, md, $urandom);
      for (int k = 0; k < 110; k++) random_vertex();
      drain();
    end

    u_chk.summarize();
    if (errors == 0) begin
      $display("height_brush_falloff_apply: match");
    end else begin
      $display("height_brush_falloff_apply: mismatch");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/hbf_pkg.sv
design/hbf_front.sv
design/hbf_queue.sv
design/hbf_back.sv
design/height_brush_falloff_apply.sv
bench/hbf_checker.sv
bench/tb_height_brush_falloff_apply.sv
